// ===== rtl/ase_pkg.sv =====
// ----------------------------------------------------------------------------
// ase_pkg
// Shared types and constants for the ascending sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ase_pkg;

  // Width of one stored element.
  localparam int unsigned DATA_W = 32;

  // Phases of the sequencer.
  typedef enum logic [1:0] {
    ST_LOAD = 2'd0,
    ST_SORT = 2'd1,
    ST_EMIT = 2'd2
  } ase_state_t;

  // Per-cycle command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic sort_en;  // compare-exchange step this cycle
    logic odd;      // active pairs start at odd positions
    logic shift;    // move the chain one cell toward the head
  } ase_ctrl_t;

endpackage : ase_pkg

`default_nettype wire

// ===== rtl/ase_if.sv =====
// ----------------------------------------------------------------------------
// ase_if
// Valid/ready channel interfaces for the input and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: one element per transfer, with an end-of-set flag.
interface ase_in_if
  import ase_pkg::*;
();
  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] value;
  logic              last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface : ase_in_if

// Result channel: one sorted element per transfer, with an end-of-set flag.
interface ase_out_if
  import ase_pkg::*;
();
  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic              last_result;

  modport source (output valid, output sorted_value, output last_result, input ready);
  modport sink   (input valid, input sorted_value, input last_result, output ready);
endinterface : ase_out_if

`default_nettype wire

// ===== rtl/ase_cell.sv =====
// ----------------------------------------------------------------------------
// ase_cell
// One position of the sorting chain: holds a value and its valid bit,
// loads from the input, exchanges with its right neighbor and shifts left.
// ----------------------------------------------------------------------------
`default_nettype none

module ase_cell
  import ase_pkg::*;
#(
  parameter bit IS_ODD    = 1'b0,
  parameter bit HAS_RIGHT = 1'b1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ase_ctrl_t                ctrl,
  input  wire logic                     load_en,
  input  wire logic signed [DATA_W-1:0] load_val,
  input  wire logic signed [DATA_W-1:0] left_val,
  input  wire logic                     left_swap,
  input  wire logic signed [DATA_W-1:0] right_val,
  input  wire logic                     right_valid,
  output      logic signed [DATA_W-1:0] val_r,
  output      logic                     valid_r,
  output      logic                     swap_right
);

  logic signed [DATA_W-1:0] val_nxt;
  logic                     valid_nxt;

  // This cell is the left member of an active pair and holds the larger value.
  assign swap_right = HAS_RIGHT && ctrl.sort_en && (ctrl.odd == IS_ODD) &&
                      valid_r && right_valid && (val_r > right_val);

  // Next value: load, shift toward the head, or take part in an exchange.
  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (load_en) begin
      val_nxt   = load_val;
      valid_nxt = 1'b1;
    end else if (ctrl.shift) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end else if (swap_right) begin
      val_nxt = right_val;
    end else if (left_swap) begin
      val_nxt = left_val;
    end
  end

  // The valid bit is control state; the value needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule : ase_cell

`default_nettype wire

// ===== rtl/ase_seq.sv =====
// ----------------------------------------------------------------------------
// ase_seq
// Sequencer: counts loaded elements, runs the transposition phases and
// drives the chain shift while results drain.
// ----------------------------------------------------------------------------
`default_nettype none

module ase_seq
  import ase_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned IDX_W   = $clog2(CAPACITY)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_xfer,
  input  wire logic             in_last,
  input  wire logic             out_xfer,
  input  wire logic             out_last,
  output      logic             in_ready,
  output      logic             emitting,
  output      logic [IDX_W-1:0] count_r,
  output      ase_ctrl_t        ctrl
);

  ase_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] count_nxt;
  logic [IDX_W-1:0] phase_r, phase_nxt;

  // State, element count and phase counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Next state and per-cycle commands.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    phase_nxt    = phase_r;
    in_ready     = 1'b0;
    emitting     = 1'b0;
    ctrl.sort_en = 1'b0;
    ctrl.odd     = phase_r[0];
    ctrl.shift   = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          count_nxt = count_r + 1'b1;
          // A flagged item or the one that fills the chain ends the set.
          if (in_last || (count_r == IDX_W'(CAPACITY - 1))) begin
            state_nxt = ST_SORT;
            count_nxt = '0;
            phase_nxt = '0;
          end
        end
      end
      ST_SORT: begin
        ctrl.sort_en = 1'b1;
        phase_nxt    = phase_r + 1'b1;
        if (phase_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emitting   = 1'b1;
        ctrl.shift = out_xfer;
        if (out_xfer && out_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule : ase_seq

`default_nettype wire

// ===== rtl/ascending_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// ascending_sort_engine_core
// Collects a set of signed 32-bit values, sorts them ascending (stable) on a
// chain of compare-exchange cells, and streams them out in order.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  (sink): one value per transfer; last_item closes the set. The
//     transfer that fills all CAPACITY cells closes the set as well.
//   out_if (source): one sorted_value per transfer, ascending; last_result
//     marks the final value of the set. Equal values keep arrival order.
// Sequence:
//   A set is loaded, then sorted by odd-even transposition in which every
//   active cell pair works in parallel, then drained as the receiver takes
//   results. The sort pass runs over the whole chain depth, so it does not
//   shorten for small sets.
// Flow:
//   in_if.ready is high only while a set is loading. Results come straight
//   from the head cell's register; a stalled receiver simply holds the chain.
//   After the last result is taken, the next set may load at once.
// Reset:
//   Synchronous, active low. All cells become empty and loading resumes.
// ----------------------------------------------------------------------------
`default_nettype none

module ascending_sort_engine_core
  import ase_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ase_in_if.sink     in_if,
  ase_out_if.source  out_if
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  ase_ctrl_t                ctrl;
  logic [IDX_W-1:0]         count_r;
  logic                     emitting;
  logic                     in_xfer;
  logic                     out_xfer;
  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_swap;

  // Handshakes.
  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_xfer = out_if.valid && out_if.ready;

  // Result comes from the head of the chain.
  assign out_if.valid        = emitting && cell_valid[0];
  assign out_if.sorted_value = cell_val[0];
  assign out_if.last_result  = !cell_valid[1];

  ase_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_xfer  (in_xfer),
    .in_last  (in_if.last_item),
    .out_xfer (out_xfer),
    .out_last (out_if.last_result),
    .in_ready (in_if.ready),
    .emitting (emitting),
    .count_r  (count_r),
    .ctrl     (ctrl)
  );

  // The chain of cells; each but the tail exchanges with its right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     load_en;
    logic signed [DATA_W-1:0] left_val;
    logic                     left_swap;
    logic signed [DATA_W-1:0] right_val;
    logic                     right_valid;

    assign load_en = in_xfer && (count_r == IDX_W'(i));

    if (i == 0) begin : g_head
      assign left_val  = '0;
      assign left_swap = 1'b0;
    end else begin : g_body
      assign left_val  = cell_val[i-1];
      assign left_swap = cell_swap[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_val   = cell_val[i+1];
      assign right_valid = cell_valid[i+1];
    end

    ase_cell #(
      .IS_ODD    (1'(i % 2)),
      .HAS_RIGHT (i != CAPACITY - 1)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .load_en     (load_en),
      .load_val    (in_if.value),
      .left_val    (left_val),
      .left_swap   (left_swap),
      .right_val   (right_val),
      .right_valid (right_valid),
      .val_r       (cell_val[i]),
      .valid_r     (cell_valid[i]),
      .swap_right  (cell_swap[i])
    );
  end

`ifndef SYNTHESIS
  // Loading and draining never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input accepted while results are pending");

  // Occupied cells always form an unbroken run from the head.
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("gap in occupied cells");

  // A closing input transfer stops further loading.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_if.last_item) |=> !in_if.ready)
    else $error("loading continued after end of set");

  // After the final result the chain is empty and loading resumes.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_if.last_result) |=> (in_if.ready && (cell_valid == '0)))
    else $error("chain not empty after last result");
`endif

endmodule : ascending_sort_engine_core

`default_nettype wire

// ===== sim/ase_result_checker.sv =====
// ----------------------------------------------------------------------------
// ase_result_checker
// Watches both channels of the sort engine, rebuilds each set from the input
// transfers, sorts it on its own and checks every result transfer against the
// oldest pending sorted element.
// ----------------------------------------------------------------------------
module ase_result_checker
  import ase_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ase_in_if         in_mon,
  ase_out_if        out_mon,
  output int        mismatches,
  output int        outstanding,
  output int        results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result transfer.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_result;
  } sorted_elem_t;

  // Values of the set that is still loading.
  logic signed [DATA_W-1:0] open_set[$];
  // Sorted elements still waiting for their result transfer.
  sorted_elem_t             sorted_due[$];

  int error_tally   = 0;
  int checked_tally = 0;

  // Close the loading set: a stable ascending sort, then queue every element.
  task automatic close_set();
    logic signed [DATA_W-1:0] work[$];
    logic signed [DATA_W-1:0] key;
    sorted_elem_t             elem;
    int                       j;
    work = open_set;
    // Insertion sort with a strict compare keeps equal values in arrival order.
    for (int i = 1; i < work.size(); i++) begin
      key = work[i];
      j   = i - 1;
      while (j >= 0 && work[j] > key) begin
        work[j + 1] = work[j];
        j--;
      end
      work[j + 1] = key;
    end
    foreach (work[k]) begin
      elem.sorted_value = work[k];
      elem.last_result  = (k == work.size() - 1);
      sorted_due.push_back(elem);
    end
    open_set.delete();
  endtask

  // Compare one result transfer with the oldest pending element.
  task automatic check_result();
    sorted_elem_t want;
    checked_tally++;
    if (sorted_due.size() == 0) begin
      error_tally++;
      if (error_tally <= 10) begin
        $display("[%0t] unexpected result: sorted_value=%0d last_result=%0b",
                 $realtime, out_mon.sorted_value, out_mon.last_result);
      end
    end else begin
      want = sorted_due.pop_front();
      if (out_mon.sorted_value !== want.sorted_value ||
          out_mon.last_result !== want.last_result) begin
        error_tally++;
        if (error_tally <= 10) begin
          $display("[%0t] mismatch: expected sorted_value=%0d last_result=%0b, got %0d %0b",
                   $realtime, want.sorted_value, want.last_result,
                   out_mon.sorted_value, out_mon.last_result);
        end
      end
    end
  endtask

  // Sample both channels at the rising edge; outputs are published a step later.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        open_set.push_back(in_mon.value);
        if (in_mon.last_item || open_set.size() == CAPACITY) begin
          close_set();
        end
      end
    end
    mismatches      <= error_tally;
    outstanding     <= sorted_due.size() + open_set.size();
    results_checked <= checked_tally;
  end

endmodule : ase_result_checker

// ===== sim/tb_ascending_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// tb_ascending_sort_engine_core
// Stimulus and verdict for the ascending sort engine: directed sets for the
// extremes and the store-full case, then random sets under four flow-control
// phases, with a separate checker predicting every sorted result.
// ----------------------------------------------------------------------------
module tb_ascending_sort_engine_core;
  import ase_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY       = 16;
  localparam int          PHASE_ITEMS    = 64;
  localparam int          WATCHDOG_LIMIT = 1000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ase_in_if  in_if ();
  ase_out_if out_if ();

  int chk_mismatches;
  int chk_outstanding;
  int chk_results;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int items_sent    = 0;
  int sets_sent     = 0;
  int quiet_cycles  = 0;
  int rx_cycle      = 0;

  ascending_sort_engine_core #(.CAPACITY(CAPACITY)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  ase_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .mismatches      (chk_mismatches),
    .outstanding     (chk_outstanding),
    .results_checked (chk_results)
  );

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Known input values from time zero.
  initial begin
    in_if.valid     = 1'b0;
    in_if.value     = '0;
    in_if.last_item = 1'b0;
  end

  // Receiver: stalls at random, with a recurring stall-free window.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 128 < 20) begin
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Value mix: extremes, zero and minus one, a narrow band for duplicates,
  // and full-range random patterns.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return $urandom_range(0, 1) ? 0 : -1;
      3, 4:    return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // One input transfer; entered and left at a falling edge.
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic lst,
                           input bit no_gap);
    int gap;
    gap = 0;
    if (!no_gap) begin
      while ($urandom_range(0, 99) < in_idle_pct && gap < 40) gap++;
    end
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.value     = v;
    in_if.last_item = lst;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // A random set; a full set may or may not flag its final value.
  task automatic send_random_set();
    int   size;
    bit   burst;
    logic lst;
    size  = ($urandom_range(0, 7) == 0) ? CAPACITY : $urandom_range(1, CAPACITY);
    burst = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < size; i++) begin
      if (i == size - 1) begin
        lst = (size == CAPACITY) ? logic'($urandom_range(0, 1)) : 1'b1;
      end else begin
        lst = 1'b0;
      end
      send_item(pick_value(), lst, burst);
    end
    sets_sent++;
  endtask

  // Main sequence: reset, directed sets, random phases, drain and verdict.
  initial begin
    int in_phase[4];
    int out_phase[4];
    int phase_start;
    logic signed [DATA_W-1:0] extremes[6];
    in_phase  = '{0, 69, 0, 24};
    out_phase = '{0, 0, 69, 24};
    extremes  = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh7FFF_FFFF};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Single element set holding the most negative value.
    send_item(32'sh8000_0000, 1'b1, 1'b1);
    sets_sent++;
    // Both extremes, zero, minus one, one and a repeated maximum.
    foreach (extremes[i]) send_item(extremes[i], (i == 5), 1'b1);
    sets_sent++;
    // A full store closes the set with last_item never set; the values come
    // in descending pairs, so the set arrives reversed with every value repeated.
    for (int i = 0; i < CAPACITY; i++) send_item(7 - i / 2, 1'b0, 1'b1);
    sets_sent++;

    // Random sets under each flow-control phase.
    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = in_phase[p];
      out_stall_pct = out_phase[p];
      phase_start   = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_set();
    end
    in_if.valid = 1'b0;

    // Drain, then let the pipeline settle.
    while (chk_outstanding != 0) @(posedge clk);
    repeat (2 * CAPACITY + 8) @(posedge clk);

    $display("Covered %0d sets of 1 to %0d values: %0d input transfers, %0d results checked,",
             sets_sent, CAPACITY, items_sent, chk_results);
    $display("under free-flowing, sender-idle, receiver-stall and mixed phases.");
    if (chk_mismatches == 0 && chk_outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : tb_ascending_sort_engine_core

// ===== filelist.f =====
rtl/ase_pkg.sv
rtl/ase_if.sv
rtl/ase_cell.sv
rtl/ase_seq.sv
rtl/ascending_sort_engine_core.sv
sim/ase_result_checker.sv
sim/tb_ascending_sort_engine_core.sv
